FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files of the block cache tag engine.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define HBC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block cache check failed");

// Next-cycle implication, held off while reset is high.
`define HBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block cache check failed");

`endif

FILE: hdl/hbc_pkg.sv
// Shared constants, types and helper functions of the block cache tag engine.
// Used by hbc_store, hbc_cmp, the top level and the checker; depends on nothing.
package hbc_pkg;

  // Geometry of the cache.
  localparam int ENTRIES  = 32;
  localparam int BUCKETS  = 13;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int RANK_W   = IDX_W;

  // Field widths.
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 24;
  localparam int REFS_W   = 8;
  localparam int STAMP_W  = 32;
  localparam int BUCKET_W = 4;
  localparam int SLOT_W   = 5;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  // The bucket hash consumes the block number one nibble per cycle.
  localparam int NIB_W    = 4;
  localparam int NIBBLES  = BLK_W / NIB_W;
  localparam int HCNT_W   = $clog2(NIBBLES);
  localparam int MOD_W    = BUCKET_W + NIB_W;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REFERR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_UPD,
    ST_TOUCH,
    ST_DONE
  } state_t;

  // One tag entry as held in the store.
  typedef struct packed {
    logic [DEV_W-1:0]    device;
    logic [BLK_W-1:0]    block;
    logic [REFS_W-1:0]   refs;
    logic [STAMP_W-1:0]  stamp;
    logic                filled;
    logic [BUCKET_W-1:0] bucket;
    logic [RANK_W-1:0]   rank;
  } entry_t;

  // Write request into the store: one entry plus an optional list move.
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic                set_tag;
    logic [DEV_W-1:0]    device;
    logic [BLK_W-1:0]    block;
    logic                set_refs;
    logic [REFS_W-1:0]   refs;
    logic                set_stamp;
    logic [STAMP_W-1:0]  stamp;
    logic                set_filled;
    logic                move;
    logic [BUCKET_W-1:0] bucket;
    logic [RANK_W-1:0]   old_rank;
  } wr_t;

  // Best candidate seen so far during a scan.
  typedef struct packed {
    logic                found;
    logic [STAMP_W-1:0]  stamp;
    logic [BUCKET_W-1:0] bucket;
    logic [RANK_W-1:0]   rank;
  } best_t;

  // Verdict of the compare unit for the entry under the scan pointer.
  typedef struct packed {
    logic hit_better;
    logic own_better;
    logic steal_better;
  } cmp_t;

  // One step of the bucket hash: (16 * r + nib) mod BUCKETS, with r < BUCKETS.
  // The input stays below 16 * BUCKETS, so a restoring subtract of 8, 4, 2
  // and 1 times BUCKETS leaves the remainder.
  function automatic logic [BUCKET_W-1:0] mod_step(input logic [BUCKET_W-1:0] r,
                                                   input logic [NIB_W-1:0] nib);
    logic [MOD_W-1:0] v;
    v = {r, nib};
    for (int k = NIB_W - 1; k >= 0; k--) begin
      if (v >= MOD_W'(BUCKETS << k)) begin
        v = v - MOD_W'(BUCKETS << k);
      end
    end
    return v[BUCKET_W-1:0];
  endfunction

endpackage

FILE: hdl/hashed_block_cache_lru_top.sv
// Top level of the block cache tag engine: sequencer, bucket hash and the
// output register around hbc_store and the shared compare unit hbc_cmp.
// Depends on hbc_pkg, hbc_store and hbc_cmp.
//
//  Channel   Handshake            Payload
//  request   req_valid/req_stall  cmd, device, block_number, slot, now
//  result    rsp_valid/rsp_stall  slot_out, hit, need_read, status
//
// A get runs through the hash steps (one nibble of the block number each), the scan
// steps (one entry each through the single read port of the store and the compare
// unit), an update step and a load into the output register. Release, pin and
// unpin run a touch step and a load.
// Reset is synchronous and restores every entry to its initial tag and place.
// req_stall is high from acceptance until the result is loaded, so the next request
// is taken only after that load; a stalled result holds the block before that load.
module hashed_block_cache_lru_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [hbc_pkg::CMD_W-1:0]    cmd,
  input  logic [hbc_pkg::DEV_W-1:0]    device,
  input  logic [hbc_pkg::BLK_W-1:0]    block_number,
  input  logic [hbc_pkg::SLOT_W-1:0]   slot,
  input  logic [hbc_pkg::STAMP_W-1:0]  now,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [hbc_pkg::SLOT_W-1:0]   slot_out,
  output logic                         hit,
  output logic                         need_read,
  output logic [hbc_pkg::STAT_W-1:0]   status
);

  hbc_pkg::state_t state;
  hbc_pkg::state_t state_next;

  // Request registers.
  hbc_pkg::cmd_t                  cmd_r;
  logic [hbc_pkg::DEV_W-1:0]      dev_r;
  logic [hbc_pkg::BLK_W-1:0]      blk_key;
  logic [hbc_pkg::BLK_W-1:0]      blk_sh;
  logic [hbc_pkg::SLOT_W-1:0]     slot_r;
  logic [hbc_pkg::STAMP_W-1:0]    now_r;

  // Sequencer counters and the hashed bucket.
  logic [hbc_pkg::HCNT_W-1:0]     hcnt;
  logic [hbc_pkg::IDX_W-1:0]      cnt;
  logic [hbc_pkg::BUCKET_W-1:0]   own;

  // Best candidates of the scan.
  hbc_pkg::best_t                 hit_best;
  hbc_pkg::best_t                 own_best;
  hbc_pkg::best_t                 st_best;
  logic [hbc_pkg::IDX_W-1:0]      hit_idx;
  logic [hbc_pkg::IDX_W-1:0]      own_idx;
  logic [hbc_pkg::IDX_W-1:0]      st_idx;
  logic [hbc_pkg::REFS_W-1:0]     hit_refs;
  logic                           hit_filled;

  // Result waiting for the output register.
  logic [hbc_pkg::SLOT_W-1:0]     res_slot;
  logic                           res_hit;
  logic                           res_read;
  logic [hbc_pkg::STAT_W-1:0]     res_status;

  logic [hbc_pkg::SLOT_W-1:0]     upd_slot;
  logic                           upd_hit;
  logic                           upd_read;
  logic [hbc_pkg::STAT_W-1:0]     upd_status;

  logic [hbc_pkg::IDX_W-1:0]      rd_idx;
  logic [hbc_pkg::IDX_W-1:0]      slot_idx;
  logic                           slot_ok;
  logic                           load_out;
  hbc_pkg::entry_t                rd;
  hbc_pkg::wr_t                   wr;
  hbc_pkg::cmp_t                  verdict;

  hbc_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .wr     (wr),
    .rd     (rd)
  );

  hbc_cmp u_cmp (
    .ent      (rd),
    .own      (own),
    .device   (dev_r),
    .block    (blk_key),
    .hit_best (hit_best),
    .own_best (own_best),
    .st_best  (st_best),
    .res      (verdict)
  );

  assign slot_idx  = hbc_pkg::IDX_W'(slot_r);
  assign slot_ok   = 32'(slot_r) < 32'(hbc_pkg::ENTRIES);
  assign req_stall = (state != hbc_pkg::ST_IDLE);
  assign load_out  = (state == hbc_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, store access and the result of the update step.
  always_comb begin
    state_next = state;
    rd_idx     = (state == hbc_pkg::ST_TOUCH) ? slot_idx : cnt;
    wr         = '0;
    upd_slot   = '0;
    upd_hit    = 1'b0;
    upd_read   = 1'b0;
    upd_status = hbc_pkg::STAT_OK;

    case (state)
      hbc_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (cmd == hbc_pkg::CMD_GET) ? hbc_pkg::ST_HASH : hbc_pkg::ST_TOUCH;
        end
      end

      hbc_pkg::ST_HASH: begin
        if (hcnt == hbc_pkg::HCNT_W'(hbc_pkg::NIBBLES - 1)) begin
          state_next = hbc_pkg::ST_SCAN;
        end
      end

      hbc_pkg::ST_SCAN: begin
        if (cnt == hbc_pkg::IDX_W'(hbc_pkg::ENTRIES - 1)) begin
          state_next = hbc_pkg::ST_UPD;
        end
      end

      // Get: a hit adds a reference, else an own-bucket or stolen entry is retagged.
      hbc_pkg::ST_UPD: begin
        state_next = hbc_pkg::ST_DONE;
        if (hit_best.found) begin
          upd_slot = hbc_pkg::SLOT_W'(hit_idx);
          upd_hit  = 1'b1;
          if (hit_refs == hbc_pkg::REFS_MAX) begin
            upd_status = hbc_pkg::STAT_REFERR;
          end else begin
            wr.en         = 1'b1;
            wr.idx        = hit_idx;
            wr.set_refs   = 1'b1;
            wr.refs       = hit_refs + 1'b1;
            wr.set_filled = 1'b1;
            upd_read      = !hit_filled;
          end
        end else if (own_best.found || st_best.found) begin
          wr.en         = 1'b1;
          wr.idx        = own_best.found ? own_idx : st_idx;
          wr.set_tag    = 1'b1;
          wr.device     = dev_r;
          wr.block      = blk_key;
          wr.set_refs   = 1'b1;
          wr.refs       = hbc_pkg::REFS_W'(1);
          wr.set_filled = 1'b1;
          wr.move       = !own_best.found;
          wr.bucket     = own;
          wr.old_rank   = st_best.rank;
          upd_slot      = hbc_pkg::SLOT_W'(wr.idx);
          upd_read      = 1'b1;
        end else begin
          upd_status = hbc_pkg::STAT_NOFREE;
        end
      end

      // Release, pin and unpin: read-modify-write of one reference count.
      hbc_pkg::ST_TOUCH: begin
        state_next = hbc_pkg::ST_DONE;
        upd_slot   = slot_r;
        wr.idx     = slot_idx;
        wr.stamp   = now_r;
        if (!slot_ok) begin
          upd_status = hbc_pkg::STAT_REFERR;
        end else if (cmd_r == hbc_pkg::CMD_PIN) begin
          if (rd.refs == hbc_pkg::REFS_MAX) begin
            upd_status = hbc_pkg::STAT_REFERR;
          end else begin
            wr.en       = 1'b1;
            wr.set_refs = 1'b1;
            wr.refs     = rd.refs + 1'b1;
          end
        end else if (rd.refs == '0) begin
          upd_status = hbc_pkg::STAT_REFERR;
        end else begin
          wr.en        = 1'b1;
          wr.set_refs  = 1'b1;
          wr.refs      = rd.refs - 1'b1;
          wr.set_stamp = (rd.refs == hbc_pkg::REFS_W'(1));
        end
      end

      hbc_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = hbc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = hbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Candidate flags are control state and clear on reset and on each request.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_best <= '0;
      own_best <= '0;
      st_best  <= '0;
    end else if (state == hbc_pkg::ST_IDLE && req_valid) begin
      hit_best.found <= 1'b0;
      own_best.found <= 1'b0;
      st_best.found  <= 1'b0;
    end else if (state == hbc_pkg::ST_SCAN) begin
      if (verdict.hit_better) begin
        hit_best <= '{found: 1'b1, stamp: rd.stamp, bucket: rd.bucket, rank: rd.rank};
      end
      if (verdict.own_better) begin
        own_best <= '{found: 1'b1, stamp: rd.stamp, bucket: rd.bucket, rank: rd.rank};
      end
      if (verdict.steal_better) begin
        st_best <= '{found: 1'b1, stamp: rd.stamp, bucket: rd.bucket, rank: rd.rank};
      end
    end
  end

  // Datapath registers: request capture, hash, scan pointer and result.
  always_ff @(posedge clk) begin
    case (state)
      hbc_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd_r   <= hbc_pkg::cmd_t'(cmd);
          dev_r   <= device;
          blk_key <= block_number;
          blk_sh  <= block_number;
          slot_r  <= slot;
          now_r   <= now;
          hcnt    <= '0;
          cnt     <= '0;
          own     <= '0;
        end
      end

      // Bucket = block mod bucket count, most significant nibble first.
      hbc_pkg::ST_HASH: begin
        own    <= hbc_pkg::mod_step(own, blk_sh[hbc_pkg::BLK_W-1 -: hbc_pkg::NIB_W]);
        blk_sh <= blk_sh << hbc_pkg::NIB_W;
        hcnt   <= hcnt + 1'b1;
      end

      hbc_pkg::ST_SCAN: begin
        cnt <= cnt + 1'b1;
        if (verdict.hit_better) begin
          hit_idx    <= cnt;
          hit_refs   <= rd.refs;
          hit_filled <= rd.filled;
        end
        if (verdict.own_better) begin
          own_idx <= cnt;
        end
        if (verdict.steal_better) begin
          st_idx <= cnt;
        end
      end

      hbc_pkg::ST_UPD, hbc_pkg::ST_TOUCH: begin
        res_slot   <= upd_slot;
        res_hit    <= upd_hit;
        res_read   <= upd_read;
        res_status <= upd_status;
      end

      default: begin
      end
    endcase
  end

  // Output register: loads when empty or when its result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      slot_out  <= res_slot;
      hit       <= res_hit;
      need_read <= res_read;
      status    <= res_status;
    end
  end

endmodule

FILE: hdl/hbc_store.sv
// Tag store of the block cache: one register set per entry, one read port and
// one write port, plus the rank shift that moves a stolen entry to its list head.
// Depends on hbc_pkg.
module hbc_store (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [hbc_pkg::IDX_W-1:0] rd_idx,
  input  hbc_pkg::wr_t             wr,
  output hbc_pkg::entry_t          rd
);

  hbc_pkg::entry_t entries [hbc_pkg::ENTRIES];

  // Each entry resets to an empty tag in bucket index mod bucket count.
  for (genvar g = 0; g < hbc_pkg::ENTRIES; g++) begin : g_entry
    localparam logic [hbc_pkg::BUCKET_W-1:0] RST_BKT =
      hbc_pkg::BUCKET_W'(g % hbc_pkg::BUCKETS);
    localparam logic [hbc_pkg::RANK_W-1:0] RST_RANK = hbc_pkg::RANK_W'(g);

    always_ff @(posedge clk) begin
      if (rst) begin
        entries[g].device <= '0;
        entries[g].block  <= '0;
        entries[g].refs   <= '0;
        entries[g].stamp  <= '0;
        entries[g].filled <= 1'b0;
        entries[g].bucket <= RST_BKT;
        entries[g].rank   <= RST_RANK;
      end else if (wr.en && wr.idx == hbc_pkg::IDX_W'(g)) begin
        if (wr.set_tag) begin
          entries[g].device <= wr.device;
          entries[g].block  <= wr.block;
        end
        if (wr.set_refs) begin
          entries[g].refs <= wr.refs;
        end
        if (wr.set_stamp) begin
          entries[g].stamp <= wr.stamp;
        end
        if (wr.set_filled) begin
          entries[g].filled <= 1'b1;
        end
        if (wr.move) begin
          entries[g].bucket <= wr.bucket;
          entries[g].rank   <= hbc_pkg::RANK_W'(hbc_pkg::ENTRIES - 1);
        end
      end else if (wr.en && wr.move && entries[g].rank > wr.old_rank) begin
        // Entries above the moved one close the gap it leaves.
        entries[g].rank <= entries[g].rank - 1'b1;
      end
    end
  end

  // Single read port.
  assign rd = entries[rd_idx];

endmodule

FILE: hdl/hbc_cmp.sv
// Shared compare unit of the block cache scan: rates the entry under the scan
// pointer against the best hit, own-bucket victim and steal victim so far.
// Depends on hbc_pkg.
module hbc_cmp (
  input  hbc_pkg::entry_t               ent,
  input  logic [hbc_pkg::BUCKET_W-1:0]  own,
  input  logic [hbc_pkg::DEV_W-1:0]     device,
  input  logic [hbc_pkg::BLK_W-1:0]     block,
  input  hbc_pkg::best_t                hit_best,
  input  hbc_pkg::best_t                own_best,
  input  hbc_pkg::best_t                st_best,
  output hbc_pkg::cmp_t                 res
);

  logic own_match;
  logic tag_match;
  logic is_free;
  logic own_older;
  logic st_older;
  logic st_tie;

  always_comb begin
    own_match = (ent.bucket == own);
    tag_match = own_match && (ent.device == device) && (ent.block == block);
    is_free   = (ent.refs == '0);

    // Least stamp wins; ties go to the lowest rank in the own bucket.
    own_older = (ent.stamp < own_best.stamp) ||
                ((ent.stamp == own_best.stamp) && (ent.rank < own_best.rank));

    // Across buckets, ties go to the lowest bucket, then the lowest rank.
    st_tie   = (ent.bucket < st_best.bucket) ||
               ((ent.bucket == st_best.bucket) && (ent.rank < st_best.rank));
    st_older = (ent.stamp < st_best.stamp) ||
               ((ent.stamp == st_best.stamp) && st_tie);

    // A hit prefers the list head, which carries the highest rank.
    res.hit_better   = tag_match && (!hit_best.found || ent.rank > hit_best.rank);
    res.own_better   = own_match && is_free && (!own_best.found || own_older);
    res.steal_better = !own_match && is_free && (!st_best.found || st_older);
  end

endmodule

FILE: hdl/hbc_checker.sv
// Port-level checker of the block cache tag engine, bound to the top level.
// Depends on hbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hbc_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic [hbc_pkg::SLOT_W-1:0]  slot_out,
  input  logic                        hit,
  input  logic                        need_read,
  input  logic [hbc_pkg::STAT_W-1:0]  status
);

  // A stalled result stays valid, with its slot and status unchanged.
  `HBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
  `HBC_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(slot_out) && $stable(status))

  // The engine works on one request at a time.
  `HBC_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

  // A get that finds no free entry reports nothing else.
  `HBC_ASSERT(a_nofree_clean, rsp_valid && status == hbc_pkg::STAT_NOFREE,
    !hit && !need_read && slot_out == '0)

  // A read request only comes with a granted entry.
  `HBC_ASSERT(a_read_ok, rsp_valid && need_read, status == hbc_pkg::STAT_OK)

endmodule

bind hashed_block_cache_lru_top hbc_checker u_hbc_checker (.*);

FILE: verif/tb_hashed_block_cache_lru_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the block cache tag engine: directed and random requests,
// results predicted from a private copy of the tag store and compared field by field.
// Depends on hbc_pkg and hashed_block_cache_lru_top.
module tb_hashed_block_cache_lru_top;
  import hbc_pkg::*;

  localparam int LIMIT_CYCLES     = 1_500_000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int POOL             = 48;
  localparam int MAX_REPORTS      = 40;

  // One result as seen on the result channel.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              need_read;
    logic [STAT_W-1:0] status;
  } lookup_result_t;

  // Tag store predictor and queue of results still to arrive.
  class tag_scoreboard;
    logic [DEV_W-1:0]    tag_dev [ENTRIES];
    logic [BLK_W-1:0]    tag_blk [ENTRIES];
    logic [REFS_W-1:0]   refs    [ENTRIES];
    logic [STAMP_W-1:0]  stamp   [ENTRIES];
    logic                filled  [ENTRIES];
    logic [BUCKET_W-1:0] bucket  [ENTRIES];
    logic [RANK_W-1:0]   rank    [ENTRIES];
    lookup_result_t      pending_results [$];
    lookup_result_t      last_result;
    int                  errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i]    = '0;
        stamp[i]   = '0;
        filled[i]  = 1'b0;
        bucket[i]  = BUCKET_W'(i % BUCKETS);
        rank[i]    = RANK_W'(i);
      end
      errors = 0;
    endfunction

    function int count_held();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (refs[i] != '0) n++;
      end
      return n;
    endfunction

    // Unreferenced entry of least stamp, either in the own bucket or in all the others.
    // Ties go to the lowest bucket, then to the lowest rank.
    function int pick_free(logic [BUCKET_W-1:0] own, bit steal);
      int best;
      bit in_scope;
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        in_scope = steal ? (bucket[i] != own) : (bucket[i] == own);
        if (in_scope && refs[i] == '0) begin
          if (best < 0) begin
            best = i;
          end else if (stamp[i] < stamp[best] ||
                       (stamp[i] == stamp[best] &&
                        (bucket[i] < bucket[best] ||
                         (bucket[i] == bucket[best] && rank[i] < rank[best])))) begin
            best = i;
          end
        end
      end
      return best;
    endfunction

    // A stolen entry joins the head of its new bucket's list.
    function void move_to_head(int e, logic [BUCKET_W-1:0] own);
      logic [RANK_W-1:0] old_rank;
      old_rank = rank[e];
      for (int i = 0; i < ENTRIES; i++) begin
        if (rank[i] > old_rank) rank[i] = rank[i] - 1'b1;
      end
      rank[e]   = RANK_W'(ENTRIES - 1);
      bucket[e] = own;
    endfunction

    // Applies one accepted request to the store and queues the result it causes.
    function void note_request(cmd_t c, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                               logic [SLOT_W-1:0] s, logic [STAMP_W-1:0] t);
      lookup_result_t r;
      logic [BUCKET_W-1:0] own;
      int e;
      r = '0;
      if (c == CMD_GET) begin
        own = BUCKET_W'(int'(blk) % BUCKETS);
        e = -1;
        // Among matching tags the list head wins.
        for (int i = 0; i < ENTRIES; i++) begin
          if (bucket[i] == own && tag_dev[i] == dev && tag_blk[i] == blk) begin
            if (e < 0) e = i;
            else if (rank[i] > rank[e]) e = i;
          end
        end
        if (e >= 0) begin
          r.slot = SLOT_W'(e);
          r.hit  = 1'b1;
          if (refs[e] == REFS_MAX) begin
            r.status = STAT_REFERR;
          end else begin
            refs[e]     = refs[e] + 1'b1;
            r.need_read = !filled[e];
            filled[e]   = 1'b1;
          end
        end else begin
          e = pick_free(own, 1'b0);
          if (e < 0) begin
            e = pick_free(own, 1'b1);
            if (e >= 0) move_to_head(e, own);
          end
          if (e < 0) begin
            r.status = STAT_NOFREE;
          end else begin
            tag_dev[e]  = dev;
            tag_blk[e]  = blk;
            refs[e]     = REFS_W'(1);
            filled[e]   = 1'b1;
            r.slot      = SLOT_W'(e);
            r.need_read = 1'b1;
          end
        end
      end else begin
        r.slot = s;
        if (int'(s) >= ENTRIES) begin
          r.status = STAT_REFERR;
        end else if (c == CMD_PIN) begin
          if (refs[s] == REFS_MAX) r.status = STAT_REFERR;
          else refs[s] = refs[s] + 1'b1;
        end else begin
          // Release and unpin stamp the entry when its last reference goes.
          if (refs[s] == '0) begin
            r.status = STAT_REFERR;
          end else begin
            refs[s] = refs[s] - 1'b1;
            if (refs[s] == '0) stamp[s] = t;
          end
        end
      end
      pending_results.push_back(r);
      last_result = r;
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(logic [SLOT_W-1:0] s, logic h, logic nr,
                               logic [STAT_W-1:0] st);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, actual slot_out %0d hit %0d need_read %0d status %0d",
                   $time, s, h, nr, st);
        end
        return;
      end
      want = pending_results.pop_front();
      if (s != want.slot) flag("slot_out", want.slot, s);
      if (h !== want.hit) flag("hit", want.hit, h);
      if (nr !== want.need_read) flag("need_read", want.need_read, nr);
      if (st != want.status) flag("status", want.status, st);
    endfunction
  endclass

  logic                clk;
  logic                rst          = 1'b1;
  logic                req_valid    = 1'b0;
  logic                req_stall;
  logic [CMD_W-1:0]    cmd          = '0;
  logic [DEV_W-1:0]    device       = '0;
  logic [BLK_W-1:0]    block_number = '0;
  logic [SLOT_W-1:0]   slot         = '0;
  logic [STAMP_W-1:0]  now          = '0;
  logic                rsp_valid;
  logic                rsp_stall    = 1'b0;
  logic [SLOT_W-1:0]   slot_out;
  logic                hit;
  logic                need_read;
  logic [STAT_W-1:0]   status;

  tag_scoreboard       sb;
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  cycle_count   = 0;
  logic [STAMP_W-1:0]  tick          = '0;
  logic [BLK_W-1:0]    block_pool [POOL];
  logic [DEV_W-1:0]    dev_pool [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};

  hashed_block_cache_lru_top dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .device       (device),
    .block_number (block_number),
    .slot         (slot),
    .now          (now),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .slot_out     (slot_out),
    .hit          (hit),
    .need_read    (need_read),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check accepted results, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_result(slot_out, hit, need_read, status);
    end
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Presents one request after an optional idle gap and waits until it is taken.
  task automatic send_request(cmd_t c, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b,
                              logic [SLOT_W-1:0] s, logic [STAMP_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    cmd          <= c;
    device       <= d;
    block_number <= b;
    slot         <= s;
    now          <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(c, d, b, s, t);
  endtask

  function automatic logic [STAMP_W-1:0] next_stamp();
    return ($urandom_range(9) == 0) ? STAMP_W'($urandom) : tick;
  endfunction

  // A referenced slot if there is one, else any slot.
  function automatic logic [SLOT_W-1:0] held_slot();
    int start;
    start = $urandom_range(ENTRIES - 1);
    for (int k = 0; k < ENTRIES; k++) begin
      if (sb.refs[(start + k) % ENTRIES] != '0) return SLOT_W'((start + k) % ENTRIES);
    end
    return SLOT_W'($urandom);
  endfunction

  // Reset tags, hit order, own-bucket ties, steals, underflow and field extremes.
  task automatic run_directed();
    send_request(CMD_GET, 8'h00, 24'd0, 5'd0, 32'd0);
    send_request(CMD_GET, 8'h00, 24'd0, 5'd31, 32'd0);
    send_request(CMD_RELEASE, 8'h00, 24'd0, 5'd26, 32'd5);
    send_request(CMD_RELEASE, 8'h00, 24'd0, 5'd26, 32'd7);
    send_request(CMD_RELEASE, 8'h00, 24'd0, 5'd26, 32'd9);
    send_request(CMD_UNPIN, 8'h00, 24'd0, 5'd3, 32'd9);
    send_request(CMD_PIN, 8'h00, 24'd0, 5'd26, 32'd0);
    send_request(CMD_UNPIN, 8'hFF, 24'hFF_FFFF, 5'd26, 32'hFFFF_FFFF);
    send_request(CMD_GET, 8'hFF, 24'hFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_request(CMD_GET, 8'h5A, 24'd13, 5'd0, 32'd0);
    send_request(CMD_GET, 8'h5A, 24'd26, 5'd0, 32'd0);
    send_request(CMD_GET, 8'h5A, 24'd39, 5'd0, 32'd0);
    send_request(CMD_GET, 8'h5A, 24'd52, 5'd0, 32'd0);
    send_request(CMD_GET, 8'h5A, 24'd65, 5'd0, 32'd0);
    send_request(CMD_GET, 8'hA5, 24'h80_0000, 5'd0, 32'd0);
    send_request(CMD_RELEASE, 8'h00, 24'd0, 5'd0, 32'd100);
    send_request(CMD_RELEASE, 8'h00, 24'd0, 5'd13, 32'd100);
    send_request(CMD_GET, 8'h5A, 24'd78, 5'd0, 32'd0);
    send_request(CMD_PIN, 8'h00, 24'd0, 5'd31, 32'd0);
    send_request(CMD_RELEASE, 8'h00, 24'd0, 5'd31, 32'd0);
    send_request(CMD_UNPIN, 8'h00, 24'd0, 5'd31, 32'h8000_0000);
  endtask

  // Drives one entry's reference count to saturation and one pin past it, then to zero and one unpin past it.
  task automatic saturate_one_entry();
    logic [DEV_W-1:0]  d;
    logic [BLK_W-1:0]  b;
    logic [SLOT_W-1:0] s;
    d = DEV_W'($urandom);
    b = BLK_W'($urandom);
    send_request(CMD_GET, d, b, 5'd0, tick);
    if (sb.last_result.status == STAT_OK) begin
      s = sb.last_result.slot;
      while (sb.refs[s] != REFS_MAX) send_request(CMD_PIN, d, b, s, tick);
      send_request(CMD_PIN, d, b, s, tick);
      send_request(CMD_GET, d, b, s, tick);
      while (sb.refs[s] != '0) begin
        tick = tick + 1'b1;
        send_request(CMD_UNPIN, d, b, s, tick);
      end
      send_request(CMD_UNPIN, d, b, s, tick);
    end
  endtask

  // Tries to take every entry, asks for one more, then releases everything entry by entry from a random start.
  task automatic fill_and_drain();
    int guard;
    int start;
    int idx;
    guard = 0;
    while (sb.count_held() < ENTRIES && guard < 2 * ENTRIES) begin
      send_request(CMD_GET, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom),
                   STAMP_W'($urandom));
      guard++;
    end
    send_request(CMD_GET, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom),
                 STAMP_W'($urandom));
    start = $urandom_range(ENTRIES - 1);
    for (int i = 0; i < ENTRIES; i++) begin
      idx = (start + i) % ENTRIES;
      while (sb.refs[idx] != '0) begin
        tick = tick + STAMP_W'($urandom_range(1));
        send_request($urandom_range(1) ? CMD_RELEASE : CMD_UNPIN, DEV_W'($urandom),
                     BLK_W'($urandom), SLOT_W'(idx), tick);
      end
    end
  endtask

  // Mostly gets from a bucket-skewed pool and releases of held entries, some noise.
  task automatic send_random();
    int pick;
    cmd_t c;
    pick = $urandom_range(99);
    tick = tick + STAMP_W'($urandom_range(2));
    if (pick < 45 && sb.count_held() >= 24) pick = 45 + int'($urandom_range(29));
    if (pick < 40) begin
      send_request(CMD_GET, dev_pool[$urandom_range(3)], block_pool[$urandom_range(POOL - 1)],
                   SLOT_W'($urandom), STAMP_W'($urandom));
    end else if (pick < 45) begin
      send_request(CMD_GET, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom),
                   STAMP_W'($urandom));
    end else if (pick < 75) begin
      c = pick[0] ? CMD_RELEASE : CMD_UNPIN;
      send_request(c, DEV_W'($urandom), BLK_W'($urandom), held_slot(), next_stamp());
    end else if (pick < 85) begin
      send_request(CMD_PIN, DEV_W'($urandom), BLK_W'($urandom), held_slot(), next_stamp());
    end else begin
      c = cmd_t'($urandom_range(3));
      send_request(c, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom),
                   STAMP_W'($urandom));
    end
  endtask

  // Main sequence: reset, directed requests, then four phases of different idle and stall percentages.
  initial begin
    sb = new();
    for (int i = 0; i < POOL; i++) begin
      if (i < POOL / 2) begin
        block_pool[i] = BLK_W'(13 * $urandom_range(4000) + $urandom_range(2));
      end else begin
        block_pool[i] = BLK_W'($urandom);
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 75;
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
        end
      endcase
      if (ph == 0) saturate_one_entry();
      fill_and_drain();
      repeat (RANDOM_PER_PHASE) send_random();
    end
    req_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
